### hdl/vbsdf_pkg.sv
// shared types, constants and the square root step for the voxel box distance block
// no dependencies
package vbsdf_pkg;

  localparam int REG_W      = 31;
  localparam int DIST_W     = 32;
  localparam int ROOT_W     = 32;
  localparam int RAD_W      = 64;
  localparam int REM_W      = 35;
  localparam int SQ_STAGES  = 16;
  localparam int FRONT_STGS = 4;
  // front stages, square, sum, root stages, output register
  localparam int NUM_STAGES = FRONT_STGS + 2 + SQ_STAGES + 1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_PITCH  = 2'd3;

  localparam logic [DIST_W-1:0] SAT_POS = 32'h7FFF_FFFF;

  // per-item flags and the inside distance, carried along the root pipeline
  typedef struct packed {
    logic [DIST_W-1:0] dist_in;
    logic              sat;
    logic              anypos;
    logic [1:0]        axis;
    logic              neg;
    logic              outside;
  } side_t;

  // front end result: flags plus the clamped positive excesses
  typedef struct packed {
    side_t                 side;
    logic [2:0][ROOT_W-1:0] h;
  } front_t;

  // state of the bitwise square root
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqst_t;

  // one result bit of the restoring square root
  function automatic sqst_t sqrt_step(input sqst_t s);
    sqst_t            o;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

### hdl/vbsdf_front.sv
// front end: cell centre, excess per axis, face normal and grid bound check
// depends on vbsdf_pkg
module vbsdf_front #(
  parameter int INDEX_BITS = 16
) (
  input  logic                                      clk,
  input  logic [vbsdf_pkg::FRONT_STGS-1:0]          en,
  input  logic [2:0][INDEX_BITS-1:0]                idx,
  input  logic [2:0][vbsdf_pkg::REG_W-1:0]          size,
  input  logic [vbsdf_pkg::REG_W-1:0]               pitch,
  output vbsdf_pkg::front_t                         front
);

  localparam int PW = INDEX_BITS + 32;
  localparam int CW = PW + 2;

  logic [2:0][PW-1:0]        p1_r;
  logic signed [CW-1:0]      twoc_r [3];
  logic                      out2_r;
  logic [CW-1:0]             mag_r [3];
  logic signed [CW-1:0]      ex_r [3];
  logic [2:0]                npos_r;
  logic                      out3_r;
  vbsdf_pkg::front_t         front_r;

  logic signed [CW-1:0]      mag_s [3];
  logic [2:0]                pos;
  logic [2:0]                big;
  logic signed [CW-1:0]      m01;
  logic signed [CW-1:0]      mmax;
  logic signed [CW-1:0]      mhalf;
  logic [1:0]                axis;
  logic [2:0]                over;

  // stage 1: (idx + 1) * pitch
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        p1_r[a] <= PW'({1'b0, idx[a]} + (INDEX_BITS+1)'(1)) * PW'(pitch);
      end
    end
  end

  // stage 2: twice the centre, 2*(idx+1)*pitch - pitch - size, and grid bound
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      over[a] = PW'(size[a]) < p1_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        twoc_r[a] <= signed'({1'b0, p1_r[a], 1'b0}) - signed'(CW'(pitch))
                     - signed'(CW'(size[a]));
      end
      out2_r <= (pitch == '0) || (|over);
    end
  end

  // stage 3: magnitude and twice the excess
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_s[a] = twoc_r[a][CW-1] ? -twoc_r[a] : twoc_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < 3; a++) begin
        mag_r[a]  <= mag_s[a];
        ex_r[a]   <= mag_s[a] - signed'(CW'(size[a]));
        npos_r[a] <= twoc_r[a][CW-1] || (twoc_r[a] == '0);
      end
      out3_r <= out2_r;
    end
  end

  // stage 4: flags, inside distance, normal, clamped excess
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = !ex_r[a][CW-1] && (ex_r[a] != '0);
      big[a] = pos[a] && (|ex_r[a][CW-2:32]);
    end
    m01   = (ex_r[1] > ex_r[0]) ? ex_r[1] : ex_r[0];
    mmax  = (ex_r[2] > m01) ? ex_r[2] : m01;
    mhalf = mmax >>> 1;
    if ((mag_r[0] > mag_r[1]) && (mag_r[0] > mag_r[2])) begin
      axis = vbsdf_pkg::AXIS_X;
    end else if (mag_r[1] > mag_r[2]) begin
      axis = vbsdf_pkg::AXIS_Y;
    end else begin
      axis = vbsdf_pkg::AXIS_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      front_r.side.dist_in <= mhalf[vbsdf_pkg::DIST_W-1:0];
      front_r.side.sat     <= |big;
      front_r.side.anypos  <= |pos;
      front_r.side.axis    <= axis;
      front_r.side.neg     <= npos_r[axis];
      front_r.side.outside <= out3_r;
      for (int a = 0; a < 3; a++) begin
        front_r.h[a] <= pos[a] ? ex_r[a][vbsdf_pkg::ROOT_W-1:0] : '0;
      end
    end
  end

  assign front = front_r;

endmodule

### hdl/vbsdf_sqrt.sv
// pipelined integer square root, two result bits per stage, flags ride along
// depends on vbsdf_pkg
module vbsdf_sqrt (
  input  logic                                 clk,
  input  logic [vbsdf_pkg::SQ_STAGES-1:0]      en,
  input  logic [vbsdf_pkg::RAD_W-1:0]          rad,
  input  vbsdf_pkg::side_t                     side_in,
  output logic [vbsdf_pkg::ROOT_W-1:0]         root,
  output vbsdf_pkg::side_t                     side_out
);

  vbsdf_pkg::sqst_t st_r   [vbsdf_pkg::SQ_STAGES];
  vbsdf_pkg::side_t side_r [vbsdf_pkg::SQ_STAGES];
  vbsdf_pkg::sqst_t st_in  [vbsdf_pkg::SQ_STAGES];

  // stage inputs: first stage starts from the radicand
  always_comb begin
    st_in[0].rem  = '0;
    st_in[0].root = '0;
    st_in[0].rad  = rad;
    for (int s = 1; s < vbsdf_pkg::SQ_STAGES; s++) begin
      st_in[s] = st_r[s-1];
    end
  end

  // each stage resolves two bits
  always_ff @(posedge clk) begin
    for (int s = 0; s < vbsdf_pkg::SQ_STAGES; s++) begin
      if (en[s]) begin
        st_r[s]   <= vbsdf_pkg::sqrt_step(vbsdf_pkg::sqrt_step(st_in[s]));
        side_r[s] <= (s == 0) ? side_in : side_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign root     = st_r[vbsdf_pkg::SQ_STAGES-1].root;
  assign side_out = side_r[vbsdf_pkg::SQ_STAGES-1];

endmodule

### hdl/voxel_box_sdf_with_face_normal.sv
// top level: config registers, pipeline flow control, squares, sum and result select
// depends on vbsdf_pkg, vbsdf_front, vbsdf_sqrt
//
// Usage:
//   Input channel in_*: one beat carries a cell index triple (i, j, k); only the
//   low INDEX_BITS of each index are used. Result channel out_*: one beat per
//   input beat, in order, with the signed Q16.16 distance to the box surface,
//   the dominant face normal axis and sign, and the outside-grid flag.
//   Registers (box sizes x/y/z, cell pitch) sit on the APB port at byte
//   addresses 0, 4, 8, 12 and must be written only while the block is idle;
//   the block itself does not enforce this. A beat passes four front stages
//   (multiply, centre, excess, normal), one square stage, one sum stage, a
//   16-stage square root resolving two bits per stage, and the output register.
//   Throughput is one beat per cycle while in_stall is low.
//   Each stage moves forward when the stage after it is empty or moving, so a
//   stall at the output fills bubbles first; in_stall rises only when every
//   stage holds a beat and the output is stalled. Nothing is lost or repeated.
//   Reset empties the pipeline and restores box sizes of 1.0 and a pitch of 1/16.
module voxel_box_sdf_with_face_normal #(
  parameter int INDEX_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_cell_i,
  input  logic [15:0] in_cell_j,
  input  logic [15:0] in_cell_k,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_signed_distance,
  output logic [1:0]  out_normal_axis,
  output logic        out_normal_negative,
  output logic        out_outside_grid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NST = vbsdf_pkg::NUM_STAGES;
  localparam int SQ0 = vbsdf_pkg::FRONT_STGS;
  localparam int SUM = SQ0 + 1;
  localparam int RT0 = SUM + 1;
  localparam int OUT = NST - 1;
  localparam logic [vbsdf_pkg::REG_W-1:0] SIZE_RST  = (vbsdf_pkg::REG_W)'(1) << FRACTION_BITS;
  localparam logic [vbsdf_pkg::REG_W-1:0] PITCH_RST =
    (vbsdf_pkg::REG_W)'(1) << (FRACTION_BITS - 4);

  logic [2:0][vbsdf_pkg::REG_W-1:0] size_r;
  logic [vbsdf_pkg::REG_W-1:0]      pitch_r;
  logic [NST-1:0]                   v_r;
  logic [NST-1:0]                   rdy;
  logic [2:0][INDEX_BITS-1:0]       idx;
  vbsdf_pkg::front_t                front;
  logic [2:0][vbsdf_pkg::RAD_W-1:0] sq_r;
  vbsdf_pkg::side_t                 side_sq_r;
  logic [vbsdf_pkg::RAD_W-1:0]      rad_r;
  vbsdf_pkg::side_t                 side_sum_r;
  logic [vbsdf_pkg::RAD_W+1:0]      sum3;
  logic [vbsdf_pkg::ROOT_W-1:0]     root;
  vbsdf_pkg::side_t                 side_rt;
  logic [vbsdf_pkg::DIST_W-1:0]     dist_sel;
  logic [vbsdf_pkg::DIST_W-1:0]     dist_r;
  logic [1:0]                       axis_r;
  logic                             neg_r;
  logic                             outside_r;
  logic                             anypos_r;
  logic                             cfg_wr;

  // config register write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= {3{SIZE_RST}};
      pitch_r <= PITCH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        vbsdf_pkg::REG_SIZE_X: size_r[0] <= pwdata[vbsdf_pkg::REG_W-1:0];
        vbsdf_pkg::REG_SIZE_Y: size_r[1] <= pwdata[vbsdf_pkg::REG_W-1:0];
        vbsdf_pkg::REG_SIZE_Z: size_r[2] <= pwdata[vbsdf_pkg::REG_W-1:0];
        vbsdf_pkg::REG_PITCH:  pitch_r   <= pwdata[vbsdf_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      vbsdf_pkg::REG_SIZE_X: prdata = {1'b0, size_r[0]};
      vbsdf_pkg::REG_SIZE_Y: prdata = {1'b0, size_r[1]};
      vbsdf_pkg::REG_SIZE_Z: prdata = {1'b0, size_r[2]};
      vbsdf_pkg::REG_PITCH:  prdata = {1'b0, pitch_r};
      default:               prdata = '0;
    endcase
  end

  // flow control: a stage loads when it is empty or its successor moves
  always_comb begin
    rdy[OUT] = !v_r[OUT] || !out_stall;
    for (int s = OUT - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (rdy[s]) begin
          v_r[s] <= (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  // front end
  assign idx[0] = in_cell_i[INDEX_BITS-1:0];
  assign idx[1] = in_cell_j[INDEX_BITS-1:0];
  assign idx[2] = in_cell_k[INDEX_BITS-1:0];

  vbsdf_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk   (clk),
    .en    (rdy[vbsdf_pkg::FRONT_STGS-1:0]),
    .idx   (idx),
    .size  (size_r),
    .pitch (pitch_r),
    .front (front)
  );

  // squares of the positive excesses
  always_ff @(posedge clk) begin
    if (rdy[SQ0]) begin
      for (int a = 0; a < 3; a++) begin
        sq_r[a] <= vbsdf_pkg::RAD_W'(front.h[a]) * vbsdf_pkg::RAD_W'(front.h[a]);
      end
      side_sq_r <= front.side;
    end
  end

  // sum of squares, quartered (excesses are in half units)
  assign sum3 = (vbsdf_pkg::RAD_W+2)'(sq_r[0]) + (vbsdf_pkg::RAD_W+2)'(sq_r[1])
              + (vbsdf_pkg::RAD_W+2)'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (rdy[SUM]) begin
      rad_r      <= sum3[vbsdf_pkg::RAD_W+1:2];
      side_sum_r <= side_sq_r;
    end
  end

  vbsdf_sqrt u_sqrt (
    .clk      (clk),
    .en       (rdy[RT0 +: vbsdf_pkg::SQ_STAGES]),
    .rad      (rad_r),
    .side_in  (side_sum_r),
    .root     (root),
    .side_out (side_rt)
  );

  // result select and output register
  always_comb begin
    if (side_rt.sat) begin
      dist_sel = vbsdf_pkg::SAT_POS;
    end else if (side_rt.anypos) begin
      dist_sel = root[vbsdf_pkg::ROOT_W-1] ? vbsdf_pkg::SAT_POS : root;
    end else begin
      dist_sel = side_rt.dist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[OUT]) begin
      dist_r    <= dist_sel;
      axis_r    <= side_rt.axis;
      neg_r     <= side_rt.neg;
      outside_r <= side_rt.outside;
      anypos_r  <= side_rt.anypos || side_rt.sat;
    end
  end

  assign out_valid           = v_r[OUT];
  assign out_signed_distance = dist_r;
  assign out_normal_axis     = axis_r;
  assign out_normal_negative = neg_r;
  assign out_outside_grid    = outside_r;

`ifndef SYNTH
  // input is held back only when the whole pipe is full behind a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && (&v_r)))
    else $error("input stalled with room in the pipeline");

  // distance sign agrees with the outside/inside branch
  a_dist_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && anypos_r) |-> !out_signed_distance[31])
    else $error("negative distance outside the box");

  a_dist_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !anypos_r) |-> (out_signed_distance[31] || (out_signed_distance == '0)))
    else $error("positive distance inside the box");

  // reset leaves no result beat
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");
`endif

endmodule
